// ===== design/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is applied
`define RTHH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define RTHH_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/rthh_pkg.sv =====
// shared constants, opcodes and types of the rgb to hsv histogram block
package rthh_pkg;

  localparam int unsigned BINS_PER_AXIS_DEF    = 32;
  localparam int unsigned FRACTION_BITS_DEF    = 8;
  localparam int unsigned ANGLE_ITERATIONS_DEF = 16;

  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned BIN_OUT_W   = 5;
  localparam int unsigned BIN_MAX_W   = 8;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 32;

  localparam int unsigned DIV_N_W = 64;
  localparam int unsigned DIV_D_W = 32;

  localparam int unsigned STORE_DEPTH_DEF =
    BINS_PER_AXIS_DEF * BINS_PER_AXIS_DEF * BINS_PER_AXIS_DEF;

  localparam logic [1:0] OP_SCAN  = 2'd0;
  localparam logic [1:0] OP_COUNT = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  typedef struct packed {
    logic start;
    logic bin_en;
  } cvt_ctl_t;

endpackage

// ===== design/rthh_ram.sv =====
// generic single write port, single read port ram with registered read
module rthh_ram
  import rthh_pkg::*;
#(
  parameter int unsigned WIDTH = COUNT_W,
  parameter int unsigned DEPTH = STORE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/rthh_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
module rthh_div
  import rthh_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIV_N_W-1:0] n,
  input  logic [DIV_D_W-1:0] d,
  output logic               done,
  output logic [DIV_N_W-1:0] q
);

  localparam int unsigned CNT_W = $clog2(DIV_N_W);

  logic             run_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_N_W-1:0] n_r;
  logic [DIV_N_W-1:0] q_r;
  logic [DIV_D_W-1:0] d_r;
  logic [DIV_D_W-1:0] rem_r;
  logic [DIV_D_W:0]   rem_sh;
  logic               fits;

  assign rem_sh = {rem_r, n_r[DIV_N_W-1]};
  assign fits   = rem_sh >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        n_r   <= n;
        d_r   <= d;
        rem_r <= '0;
        q_r   <= '0;
      end else if (run_r) begin
        n_r   <= {n_r[DIV_N_W-2:0], 1'b0};
        q_r   <= {q_r[DIV_N_W-2:0], fits};
        rem_r <= fits ? DIV_D_W'(rem_sh - {1'b0, d_r}) : DIV_D_W'(rem_sh);
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_N_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

// ===== design/rthh_cvt.sv =====
// pixel conversion sequencer: hsv values, square root, angle digits and bins
module rthh_cvt
  import rthh_pkg::*;
#(
  parameter int unsigned BINS_PER_AXIS    = BINS_PER_AXIS_DEF,
  parameter int unsigned FRACTION_BITS    = FRACTION_BITS_DEF,
  parameter int unsigned ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  cvt_ctl_t                         ctl,
  input  logic [7:0]                       red,
  input  logic [7:0]                       green,
  input  logic [7:0]                       blue,
  input  logic [8+FRACTION_BITS-1:0]       hmax,
  input  logic [8+FRACTION_BITS-1:0]       smax,
  input  logic [8+FRACTION_BITS-1:0]       vmax,
  output logic                             done,
  output logic [8+FRACTION_BITS-1:0]       h,
  output logic [8+FRACTION_BITS-1:0]       s,
  output logic [8+FRACTION_BITS-1:0]       v,
  output logic [$clog2(BINS_PER_AXIS)-1:0] hb,
  output logic [$clog2(BINS_PER_AXIS)-1:0] sb,
  output logic [$clog2(BINS_PER_AXIS)-1:0] vb
);

  localparam int unsigned VAL_W  = 8 + FRACTION_BITS;
  localparam int unsigned BIN_W  = $clog2(BINS_PER_AXIS);
  localparam int unsigned T_W    = ANGLE_ITERATIONS + 2;
  localparam int unsigned CNT_W  = 5;
  localparam logic [30:0] COS_ONE = 31'h4000_0000;
  localparam logic [31:0] RECIP_THREE = 32'hAAAA_AAAB;

  localparam logic [4:0] C_IDLE = 5'd0;
  localparam logic [4:0] C_PREP = 5'd1;
  localparam logic [4:0] C_RAD  = 5'd2;
  localparam logic [4:0] C_SGO  = 5'd5;
  localparam logic [4:0] C_SWT  = 5'd6;
  localparam logic [4:0] C_SQI  = 5'd7;
  localparam logic [4:0] C_SQ   = 5'd8;
  localparam logic [4:0] C_HGO  = 5'd9;
  localparam logic [4:0] C_HWT  = 5'd10;
  localparam logic [4:0] C_AA   = 5'd11;
  localparam logic [4:0] C_AB   = 5'd12;
  localparam logic [4:0] C_HUE  = 5'd13;
  localparam logic [4:0] C_BGO  = 5'd14;
  localparam logic [4:0] C_BWT  = 5'd15;
  localparam logic [4:0] C_DONE = 5'd16;

  logic [4:0]        state_r;
  logic              bin_en_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [1:0]        idx_r;
  logic [9:0]        sum_r;
  logic [7:0]        mn_r;
  logic signed [17:0] p1_r;
  logic signed [17:0] p2_r;
  logic signed [10:0] num_r;
  logic [17:0]       rad_r;
  logic [63:0]       sq_v_r;
  logic [63:0]       sq_res_r;
  logic [63:0]       sq_bit_r;
  logic signed [31:0] c_r;
  logic [61:0]       mm_r;
  logic [T_W-1:0]    t_r;
  logic              flip_r;
  logic [VAL_W-1:0]  h_r;
  logic [VAL_W-1:0]  s_r;
  logic [VAL_W-1:0]  v_r;
  logic [BIN_W-1:0]  hb_r;
  logic [BIN_W-1:0]  sb_r;
  logic [BIN_W-1:0]  vb_r;

  logic               div_start;
  logic [DIV_N_W-1:0] div_n;
  logic [DIV_D_W-1:0] div_d;
  logic               div_done;
  logic [DIV_N_W-1:0] div_q;

  logic signed [8:0]  d_rg;
  logic signed [8:0]  d_rb;
  logic signed [8:0]  d_gb;
  logic [7:0]         mn_c;
  logic [9:0]         sdiff;
  logic [9:0]         absnum;
  logic [63:0]        sq_sum;
  logic               neg;
  logic [30:0]        mag_m;
  logic [30:0]        mag;
  logic [T_W-1:0]     tt;
  logic [63:0]        hx;
  logic [VAL_W-1:0]   val_sel;
  logic [VAL_W-1:0]   max_sel;
  logic [BIN_W-1:0]   bin_q;
  logic [31:0]        v_num;
  logic [63:0]        v_prod;

  rthh_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .n     (div_n),
    .d     (div_d),
    .done  (div_done),
    .q     (div_q)
  );

  assign d_rg = $signed({1'b0, red})   - $signed({1'b0, green});
  assign d_rb = $signed({1'b0, red})   - $signed({1'b0, blue});
  assign d_gb = $signed({1'b0, green}) - $signed({1'b0, blue});

  always_comb begin
    mn_c = red;
    if (green < mn_c) begin
      mn_c = green;
    end
    if (blue < mn_c) begin
      mn_c = blue;
    end
  end

  assign sdiff  = 10'(sum_r - 10'(3 * mn_r));
  assign absnum = num_r[10] ? 10'(-num_r) : 10'(num_r);
  assign sq_sum = sq_res_r + sq_bit_r;

  // value: divide by three through the reciprocal, exact below 2^32
  assign v_num  = 32'(sum_r) << FRACTION_BITS;
  assign v_prod = 64'(v_num) * 64'(RECIP_THREE);

  // cosine in q30, clamped to one
  assign mag = (div_q > 64'(COS_ONE)) ? COS_ONE : div_q[30:0];

  assign neg   = c_r[31];
  assign mag_m = neg ? 31'(-c_r) : 31'(c_r);

  assign tt = (green < blue) ? T_W'((T_W'(1) << (ANGLE_ITERATIONS + 1)) - t_r) : t_r;
  assign hx = (((64'(tt) << 8) - 64'(tt)) << FRACTION_BITS) >> (ANGLE_ITERATIONS + 1);

  always_comb begin
    case (idx_r)
      2'd0: begin
        val_sel = h_r;
        max_sel = hmax;
      end
      2'd1: begin
        val_sel = s_r;
        max_sel = smax;
      end
      default: begin
        val_sel = v_r;
        max_sel = vmax;
      end
    endcase
  end

  assign bin_q = (div_q > 64'(BINS_PER_AXIS - 1)) ? BIN_W'(BINS_PER_AXIS - 1) :
                 div_q[BIN_W-1:0];

  always_comb begin
    div_start = 1'b0;
    div_n     = '0;
    div_d     = '0;
    case (state_r)
      C_SGO: begin
        div_start = 1'b1;
        div_n     = ((64'(sdiff) << 8) - 64'(sdiff)) << FRACTION_BITS;
        div_d     = 32'(sum_r);
      end
      C_HGO: begin
        div_start = 1'b1;
        div_n     = 64'(absnum) << 49;
        div_d     = sq_res_r[31:0];
      end
      C_BGO: begin
        div_start = (max_sel != '0);
        div_n     = 64'(32'(val_sel) * 32'(BINS_PER_AXIS - 1));
        div_d     = 32'(max_sel);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
    end else begin
      case (state_r)
        C_IDLE: begin
          if (ctl.start) begin
            bin_en_r <= ctl.bin_en;
            state_r  <= C_PREP;
          end
        end
        C_PREP: begin
          sum_r   <= 10'(red) + 10'(green) + 10'(blue);
          mn_r    <= mn_c;
          p1_r    <= d_rg * d_rg;
          p2_r    <= d_rb * d_gb;
          num_r   <= 11'(2 * $signed({3'b0, red})) - 11'($signed({3'b0, green}))
                     - 11'($signed({3'b0, blue}));
          state_r <= C_RAD;
        end
        C_RAD: begin
          rad_r <= 18'(19'(p1_r) + 19'(p2_r));
          v_r   <= VAL_W'(v_prod[63:33]);
          if (sum_r == '0) begin
            s_r     <= '0;
            state_r <= C_SQI;
          end else begin
            state_r <= C_SGO;
          end
        end
        C_SGO: state_r <= C_SWT;
        C_SWT: begin
          if (div_done) begin
            s_r     <= VAL_W'(div_q);
            state_r <= C_SQI;
          end
        end
        C_SQI: begin
          t_r <= '0;
          if (rad_r == '0) begin
            state_r <= C_HUE;
          end else begin
            sq_v_r   <= 64'(rad_r) << 40;
            sq_res_r <= '0;
            sq_bit_r <= 64'h4000_0000_0000_0000;
            cnt_r    <= '0;
            state_r  <= C_SQ;
          end
        end
        C_SQ: begin
          if (sq_v_r >= sq_sum) begin
            sq_v_r   <= sq_v_r - sq_sum;
            sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
          end else begin
            sq_res_r <= sq_res_r >> 1;
          end
          sq_bit_r <= sq_bit_r >> 2;
          cnt_r    <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(31)) begin
            state_r <= C_HGO;
          end
        end
        C_HGO: state_r <= C_HWT;
        C_HWT: begin
          if (div_done) begin
            c_r     <= num_r[10] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            flip_r  <= 1'b0;
            cnt_r   <= '0;
            state_r <= C_AA;
          end
        end
        C_AA: begin
          mm_r    <= mag_m * mag_m;
          t_r     <= {t_r[T_W-2:0], neg ^ flip_r};
          flip_r  <= flip_r ^ neg;
          state_r <= C_AB;
        end
        C_AB: begin
          // c = 2*c^2 - 1 in q30
          c_r   <= 32'((33'(mm_r[61:30]) << 1) - 33'(COS_ONE));
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(ANGLE_ITERATIONS - 1)) begin
            state_r <= C_HUE;
          end else begin
            state_r <= C_AA;
          end
        end
        C_HUE: begin
          h_r   <= VAL_W'(hx);
          idx_r <= '0;
          state_r <= bin_en_r ? C_BGO : C_DONE;
        end
        C_BGO: begin
          if (max_sel != '0) begin
            state_r <= C_BWT;
          end else begin
            case (idx_r)
              2'd0:    hb_r <= '0;
              2'd1:    sb_r <= '0;
              default: vb_r <= '0;
            endcase
            idx_r <= idx_r + 1'b1;
            if (idx_r == 2'd2) begin
              state_r <= C_DONE;
            end
          end
        end
        C_BWT: begin
          if (div_done) begin
            case (idx_r)
              2'd0:    hb_r <= bin_q;
              2'd1:    sb_r <= bin_q;
              default: vb_r <= bin_q;
            endcase
            idx_r   <= idx_r + 1'b1;
            state_r <= (idx_r == 2'd2) ? C_DONE : C_BGO;
          end
        end
        C_DONE: state_r <= C_IDLE;
        default: state_r <= C_IDLE;
      endcase
    end
  end

  assign done = (state_r == C_DONE);
  assign h    = h_r;
  assign s    = s_r;
  assign v    = v_r;
  assign hb   = hb_r;
  assign sb   = sb_r;
  assign vb   = vb_r;

endmodule

// ===== design/rgb_to_hsv_histogram.sv =====
// top level: stream handshake, histogram store read-modify-write, maxima
//
// channel  dir  tdata                                   tuser
// in_      in   red, green, blue, bin_address (40 bit)   operation (2 bit)
// out_     out  hue, sat, value bins, bin_count (32 bit) -
//
// one item at a time. the bit-serial divider dominates the time a scan or count
// takes, with up to two divisions per scan and five per count.
// after reset a clearing pass zeroes the store, one entry a cycle, BINS_PER_AXIS
// cubed entries (32768 by default), before in_tready rises.
// a finished result waits in the output register; the next transaction is
// taken meanwhile and stalls only when its own result is ready.
module rgb_to_hsv_histogram
  import rthh_pkg::*;
#(
  parameter int unsigned BINS_PER_AXIS    = BINS_PER_AXIS_DEF,
  parameter int unsigned FRACTION_BITS    = FRACTION_BITS_DEF,
  parameter int unsigned ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // red, green, blue, bin_address, pad
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // operation
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // hue_bin, saturation_bin, value_bin,
                                             // bin_count, pad
);

  localparam int unsigned DEPTH  = BINS_PER_AXIS * BINS_PER_AXIS * BINS_PER_AXIS;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned BIN_W  = $clog2(BINS_PER_AXIS);
  localparam int unsigned VAL_W  = 8 + FRACTION_BITS;

  localparam logic [2:0] T_INIT = 3'd0;
  localparam logic [2:0] T_IDLE = 3'd1;
  localparam logic [2:0] T_CVT  = 3'd2;
  localparam logic [2:0] T_RD   = 3'd3;
  localparam logic [2:0] T_UPD  = 3'd4;
  localparam logic [2:0] T_OUT  = 3'd5;

  logic [2:0]        state_r;
  logic [2:0]        state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic              cvt_start_r;
  logic [1:0]        op_r;
  logic [7:0]        red_r;
  logic [7:0]        green_r;
  logic [7:0]        blue_r;
  logic [14:0]       baddr_r;
  logic [ADDR_W-1:0] bin_addr_r;
  logic [VAL_W-1:0]  hmax_r;
  logic [VAL_W-1:0]  smax_r;
  logic [VAL_W-1:0]  vmax_r;
  logic [COUNT_W-1:0] cnt_res_r;
  logic              out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  logic              in_acc;
  logic              out_load;
  cvt_ctl_t          cvt_ctl;
  logic              cvt_done;
  logic [VAL_W-1:0]  cvt_h;
  logic [VAL_W-1:0]  cvt_s;
  logic [VAL_W-1:0]  cvt_v;
  logic [BIN_W-1:0]  cvt_hb;
  logic [BIN_W-1:0]  cvt_sb;
  logic [BIN_W-1:0]  cvt_vb;
  logic [31:0]       addr32;
  logic              in_range;
  logic [31:0]       flat32;
  logic [BIN_MAX_W-1:0] hb_ext;
  logic [BIN_MAX_W-1:0] sb_ext;
  logic [BIN_MAX_W-1:0] vb_ext;
  logic [BIN_OUT_W-1:0] hb_o;
  logic [BIN_OUT_W-1:0] sb_o;
  logic [BIN_OUT_W-1:0] vb_o;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [COUNT_W-1:0] ram_wdata;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [COUNT_W-1:0] ram_rdata;

  assign in_tready = (state_r == T_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = (state_r == T_OUT) && (!out_tvalid_r || out_tready);

  assign addr32   = 32'(baddr_r);
  assign in_range = addr32 < 32'(DEPTH);
  assign flat32   = ((32'(cvt_hb) * 32'(BINS_PER_AXIS)) + 32'(cvt_sb))
                    * 32'(BINS_PER_AXIS) + 32'(cvt_vb);

  assign cvt_ctl.start  = cvt_start_r;
  assign cvt_ctl.bin_en = (op_r == OP_COUNT);

  rthh_cvt #(
    .BINS_PER_AXIS    (BINS_PER_AXIS),
    .FRACTION_BITS    (FRACTION_BITS),
    .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
  ) u_cvt (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cvt_ctl),
    .red   (red_r),
    .green (green_r),
    .blue  (blue_r),
    .hmax  (hmax_r),
    .smax  (smax_r),
    .vmax  (vmax_r),
    .done  (cvt_done),
    .h     (cvt_h),
    .s     (cvt_s),
    .v     (cvt_v),
    .hb    (cvt_hb),
    .sb    (cvt_sb),
    .vb    (cvt_vb)
  );

  rthh_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // store ports: clearing pass, clear of one bin, bin reads, increment write-back
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_cnt_r;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = (op_r == OP_COUNT) ? bin_addr_r : addr32[ADDR_W-1:0];
    case (state_r)
      T_INIT: ram_we = 1'b1;
      T_RD: begin
        if (op_r == OP_CLEAR) begin
          ram_we    = in_range;
          ram_waddr = addr32[ADDR_W-1:0];
        end else begin
          ram_re = (op_r == OP_COUNT) || in_range;
        end
      end
      T_UPD: begin
        if (op_r == OP_COUNT) begin
          ram_we    = 1'b1;
          ram_waddr = bin_addr_r;
          ram_wdata = COUNT_W'(ram_rdata + 1'b1);
        end
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      T_INIT: begin
        if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = T_IDLE;
        end
      end
      T_IDLE: begin
        if (in_acc) begin
          state_nxt = ((in_tuser == OP_SCAN) || (in_tuser == OP_COUNT)) ? T_CVT : T_RD;
        end
      end
      T_CVT: begin
        if (cvt_done) begin
          state_nxt = (op_r == OP_COUNT) ? T_RD : T_OUT;
        end
      end
      T_RD: begin
        state_nxt = ((op_r == OP_COUNT) || ((op_r == OP_READ) && in_range)) ? T_UPD : T_OUT;
      end
      T_UPD: state_nxt = T_OUT;
      T_OUT: begin
        if (out_load) begin
          state_nxt = T_IDLE;
        end
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  assign hb_ext = BIN_MAX_W'(cvt_hb);
  assign sb_ext = BIN_MAX_W'(cvt_sb);
  assign vb_ext = BIN_MAX_W'(cvt_vb);
  assign hb_o   = (op_r == OP_COUNT) ? hb_ext[BIN_OUT_W-1:0] : '0;
  assign sb_o   = (op_r == OP_COUNT) ? sb_ext[BIN_OUT_W-1:0] : '0;
  assign vb_o   = (op_r == OP_COUNT) ? vb_ext[BIN_OUT_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= T_INIT;
      clr_cnt_r    <= '0;
      cvt_start_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
      hmax_r       <= '0;
      smax_r       <= '0;
      vmax_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      cvt_start_r <= 1'b0;
      case (state_r)
        T_INIT: clr_cnt_r <= clr_cnt_r + 1'b1;
        T_IDLE: begin
          if (in_acc) begin
            op_r        <= in_tuser;
            red_r       <= in_tdata[7:0];
            green_r     <= in_tdata[15:8];
            blue_r      <= in_tdata[23:16];
            baddr_r     <= in_tdata[38:24];
            cvt_start_r <= (in_tuser == OP_SCAN) || (in_tuser == OP_COUNT);
          end
        end
        T_CVT: begin
          if (cvt_done) begin
            cnt_res_r  <= '0;
            bin_addr_r <= flat32[ADDR_W-1:0];
            if (op_r == OP_SCAN) begin
              if (cvt_h > hmax_r) hmax_r <= cvt_h;
              if (cvt_s > smax_r) smax_r <= cvt_s;
              if (cvt_v > vmax_r) vmax_r <= cvt_v;
            end
          end
        end
        T_RD: begin
          cnt_res_r <= '0;
          if (op_r == OP_CLEAR) begin
            hmax_r <= '0;
            smax_r <= '0;
            vmax_r <= '0;
          end
        end
        T_UPD: begin
          cnt_res_r <= (op_r == OP_COUNT) ? COUNT_W'(ram_rdata + 1'b1) : ram_rdata;
        end
        default: cnt_res_r <= cnt_res_r;
      endcase
      if (out_load) begin
        out_tvalid_r <= 1'b1;
        out_tdata_r  <= {1'b0, cnt_res_r, vb_o, sb_o, hb_o};
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== design/rthh_chk.sv =====
// port-level checker for the histogram block, bound to the top level
`include "assert_macros.svh"

module rthh_chk
  import rthh_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  `RTHH_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result dropped while stalled")
  `RTHH_ASSERT(a_out_stable, out_tvalid && !out_tready |=> $stable(out_tdata), "result changed while stalled")
  `RTHH_ASSERT(a_one_at_a_time, in_tvalid && in_tready |=> !in_tready, "second transaction taken while busy")
  `RTHH_ASSERT_RST(a_reset_quiet, !rst_n |=> !out_tvalid && !in_tready, "ports active after reset")

endmodule

bind rgb_to_hsv_histogram rthh_chk u_rthh_chk (.*);

// ===== tb/sv/rgb_to_hsv_histogram_tb.sv =====
// self-checking testbench for the rgb to hsv histogram block
module rgb_to_hsv_histogram_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rthh_pkg::*;

  localparam int unsigned BINS      = BINS_PER_AXIS_DEF;
  localparam int unsigned FRAC      = FRACTION_BITS_DEF;
  localparam int unsigned ANGLES    = ANGLE_ITERATIONS_DEF;
  localparam int unsigned DEPTH     = STORE_DEPTH_DEF;
  localparam longint      COS_ONE   = longint'(1) << 30;
  localparam int          IDLE_MAX  = 150000;
  localparam int          N_ITEMS   = 1050;

  typedef struct {
    logic [1:0]  op;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [14:0] addr;
    bit          drain;
  } pixel_op_t;

  typedef struct {
    logic [4:0]  hue_bin;
    logic [4:0]  sat_bin;
    logic [4:0]  val_bin;
    logic [15:0] count;
  } bin_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  pixel_op_t   pending_ops[$];
  bin_result_t expected_bins[$];
  logic [15:0] hist_counts [DEPTH];
  logic [15:0] hue_peak, sat_peak, val_peak;
  int          fail_count;
  int          idle_cycles;
  int          burst_left, gap_left;
  int          stall_mode, stall_timer;

  rgb_to_hsv_histogram dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------- hsv arithmetic ----------------
  function automatic longint unsigned isqrt64(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = longint'(1) << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] hue_fx(int r, int g, int b);
    int              rad, num;
    longint unsigned t, d, mag, m, wide;
    longint          c;
    bit              flip, s;
    rad  = (r - g) * (r - g) + (r - b) * (g - b);
    num  = 2 * r - g - b;
    t    = 0;
    flip = 0;
    if (rad > 0) begin
      wide = rad;
      d    = isqrt64(wide << 40);
      mag  = (num < 0) ? -num : num;
      mag  = mag << 49;
      mag  = (d != 0) ? mag / d : COS_ONE;
      if (mag > COS_ONE) mag = COS_ONE;
      c = (num < 0) ? -longint'(mag) : longint'(mag);
      for (int k = 0; k < ANGLES; k++) begin
        s    = (c < 0);
        m    = (c < 0) ? -c : c;
        t    = (t << 1) | longint'(s ^ flip);
        flip = flip ^ s;
        c    = longint'(2 * ((m * m) >> 30)) - COS_ONE;
      end
    end
    if (g < b) t = (longint'(2) << ANGLES) - t;
    return 16'(((t * 255) << FRAC) >> (ANGLES + 1));
  endfunction

  function automatic void pixel_to_hsv(int r, int g, int b, output logic [15:0] h,
                                       output logic [15:0] s, output logic [15:0] v);
    longint sum, mn;
    sum = r + g + b;
    mn  = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    s = (sum == 0) ? 16'd0 : 16'(((255 * (sum - 3 * mn)) << FRAC) / sum);
    v = 16'((sum << FRAC) / 3);
    h = hue_fx(r, g, b);
  endfunction

  function automatic int unsigned axis_bin(logic [15:0] v, logic [15:0] m);
    longint unsigned q;
    if (m == 0) return 0;
    q = (longint'(BINS - 1) * v) / m;
    return (q > BINS - 1) ? BINS - 1 : int'(q);
  endfunction

  // applies one accepted transaction to the histogram state, returns what the block sends
  function automatic bin_result_t histogram_update(pixel_op_t it);
    bin_result_t res;
    logic [15:0] h, s, v;
    int unsigned hb, sb, vb, a;
    res = '{default: '0};
    case (it.op)
      OP_SCAN: begin
        pixel_to_hsv(it.red, it.green, it.blue, h, s, v);
        if (h > hue_peak) hue_peak = h;
        if (s > sat_peak) sat_peak = s;
        if (v > val_peak) val_peak = v;
      end
      OP_COUNT: begin
        pixel_to_hsv(it.red, it.green, it.blue, h, s, v);
        hb = axis_bin(h, hue_peak);
        sb = axis_bin(s, sat_peak);
        vb = axis_bin(v, val_peak);
        a  = (hb * BINS + sb) * BINS + vb;
        if (a < DEPTH) begin
          hist_counts[a] = hist_counts[a] + 16'd1;
          res.count      = hist_counts[a];
        end
        res.hue_bin = hb[4:0];
        res.sat_bin = sb[4:0];
        res.val_bin = vb[4:0];
      end
      OP_READ: begin
        if (it.addr < DEPTH) res.count = hist_counts[it.addr];
      end
      default: begin
        if (it.addr < DEPTH) hist_counts[it.addr] = '0;
        hue_peak = '0;
        sat_peak = '0;
        val_peak = '0;
      end
    endcase
    return res;
  endfunction

  // ---------------- stimulus ----------------
  task automatic push_op(logic [1:0] op, int r, int g, int b, int addr, bit drain = 0);
    pixel_op_t it;
    it.op    = op;
    it.red   = r[7:0];
    it.green = g[7:0];
    it.blue  = b[7:0];
    it.addr  = addr[14:0];
    it.drain = drain;
    pending_ops.push_back(it);
  endtask

  // clear, scan a group of pixels, count them, then read back their bins
  task automatic push_frame(bit drain);
    int          n, r[24], g[24], b[24], addrs[$];
    logic [15:0] h, s, v, hm, sm, vm;
    bit          palette;
    n       = $urandom_range(3, 24);
    palette = ($urandom_range(0, 1) == 1);
    hm = 0; sm = 0; vm = 0;
    push_op(OP_CLEAR, $urandom, $urandom, $urandom, $urandom_range(0, DEPTH - 1), drain);
    for (int i = 0; i < n; i++) begin
      if (palette) begin
        r[i] = 64 * $urandom_range(0, 3) + 63 * $urandom_range(0, 1);
        g[i] = 85 * $urandom_range(0, 3);
        b[i] = 127 * $urandom_range(0, 2);
      end else begin
        r[i] = $urandom_range(0, 255);
        g[i] = $urandom_range(0, 255);
        b[i] = $urandom_range(0, 255);
      end
      pixel_to_hsv(r[i], g[i], b[i], h, s, v);
      if (h > hm) hm = h;
      if (s > sm) sm = s;
      if (v > vm) vm = v;
      push_op(OP_SCAN, r[i], g[i], b[i], $urandom_range(0, DEPTH - 1));
    end
    for (int i = 0; i < n; i++) begin
      pixel_to_hsv(r[i], g[i], b[i], h, s, v);
      addrs.push_back((axis_bin(h, hm) * BINS + axis_bin(s, sm)) * BINS + axis_bin(v, vm));
      push_op(OP_COUNT, r[i], g[i], b[i], $urandom_range(0, DEPTH - 1));
    end
    for (int i = 0; i < $urandom_range(1, 4); i++)
      push_op(OP_READ, $urandom, $urandom, $urandom, addrs[$urandom_range(0, n - 1)]);
  endtask

  initial begin
    int total;
    fail_count = 0;
    for (int i = 0; i < DEPTH; i++) hist_counts[i] = '0;
    hue_peak = '0; sat_peak = '0; val_peak = '0;

    // count before any scan lands in bin zero
    push_op(OP_COUNT, 200, 10, 90, 0);
    push_op(OP_COUNT, 0, 0, 0, DEPTH - 1);
    push_op(OP_READ, 0, 0, 0, 0);
    push_op(OP_READ, 255, 255, 255, DEPTH - 1);
    push_op(OP_SCAN, 0, 0, 0, 0);
    push_op(OP_SCAN, 255, 0, 0, 0);
    push_op(OP_SCAN, 0, 255, 0, 0);
    push_op(OP_SCAN, 0, 0, 255, DEPTH - 1);
    push_op(OP_SCAN, 255, 255, 255, 0);
    push_op(OP_COUNT, 255, 255, 255, 0);
    push_op(OP_COUNT, 255, 0, 0, 0);
    push_op(OP_COUNT, 0, 255, 0, 0);
    push_op(OP_COUNT, 0, 0, 255, 0);
    push_op(OP_COUNT, 255, 0, 255, 0);
    push_op(OP_COUNT, 0, 0, 0, 0);
    push_op(OP_COUNT, 0, 0, 0, 0);
    push_op(OP_COUNT, 100, 100, 100, 0);
    push_op(OP_READ, 0, 0, 0, 0);
    // clear empties one bin and drops all three maxima
    push_op(OP_CLEAR, 0, 0, 0, 0);
    push_op(OP_READ, 0, 0, 0, 0);
    push_op(OP_COUNT, 10, 20, 30, 0);
    push_op(OP_CLEAR, 255, 255, 255, DEPTH - 1);

    total = pending_ops.size();
    while (total < N_ITEMS) begin
      if ($urandom_range(0, 9) < 8) begin
        push_frame($urandom_range(0, 5) == 0);
      end else begin
        for (int i = 0; i < $urandom_range(1, 6); i++)
          push_op(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom);
      end
      total = pending_ops.size();
    end
    pending_ops[30].drain = 1;

    wait (rst_n === 1'b1);
    wait (pending_ops.size() == 0 && !in_tvalid);
    wait (expected_bins.size() == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  // ---------------- driver ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      in_tdata   <= '0;
      in_tuser   <= OP_SCAN;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_tvalid && in_tready)
        expected_bins.push_back(histogram_update('{in_tuser, in_tdata[7:0], in_tdata[15:8],
                                                   in_tdata[23:16], in_tdata[38:24], 1'b0}));
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left  <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (pending_ops.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (pending_ops[0].drain &&
                     (expected_bins.size() != 0 || (in_tvalid && in_tready))) begin
          // hold off until every outstanding result has come back
          in_tvalid <= 1'b0;
        end else begin
          in_tvalid <= 1'b1;
          in_tuser  <= pending_ops[0].op;
          in_tdata  <= {1'b0, pending_ops[0].addr, pending_ops[0].blue,
                        pending_ops[0].green, pending_ops[0].red};
          void'(pending_ops.pop_front());
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 15);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // ---------------- receiver and checker ----------------
  always @(posedge clk) begin
    bin_result_t exp_r;
    if (!rst_n) begin
      out_tready  <= 1'b0;
      stall_mode  <= 0;
      stall_timer <= 0;
    end else begin
      if (stall_timer == 0) begin
        stall_mode  <= $urandom_range(0, 2);
        stall_timer <= $urandom_range(50, 400);
      end else begin
        stall_timer <= stall_timer - 1;
      end
      case (stall_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase

      if (out_tvalid && out_tready) begin
        if (expected_bins.size() == 0) begin
          $error("result transaction with no expectation: tdata=%h", out_tdata);
          fail_count++;
        end else begin
          exp_r = expected_bins.pop_front();
          if (out_tdata[4:0] !== exp_r.hue_bin) begin
            $error("hue_bin expected %0d got %0d", exp_r.hue_bin, out_tdata[4:0]);
            fail_count++;
          end
          if (out_tdata[9:5] !== exp_r.sat_bin) begin
            $error("saturation_bin expected %0d got %0d", exp_r.sat_bin, out_tdata[9:5]);
            fail_count++;
          end
          if (out_tdata[14:10] !== exp_r.val_bin) begin
            $error("value_bin expected %0d got %0d", exp_r.val_bin, out_tdata[14:10]);
            fail_count++;
          end
          if (out_tdata[30:15] !== exp_r.count) begin
            $error("bin_count expected %0d got %0d", exp_r.count, out_tdata[30:15]);
            fail_count++;
          end
        end
      end
    end
  end

  // ---------------- watchdog ----------------
  // reset clearing pass writes one store entry per cycle
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_MAX) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
